// ----- hw/rtl/bcg_pkg.sv -----
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants of the button click gesture classifier.
// ----------------------------------------------------------------------------
package bcg_pkg;

  // field widths
  localparam int unsigned DebounceW    = 8;
  localparam int unsigned LongPressW   = 12;
  localparam int unsigned ClickWindowW = 10;
  localparam int unsigned CfgDataW     = 12;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned LongsW       = 2;
  localparam int unsigned GestureW     = 2;
  localparam int unsigned VolPctW      = 7;
  localparam int unsigned ClickCntW    = 3;

  // defaults for the top-level parameters
  localparam int unsigned NumButtonsDef  = 2;
  localparam int unsigned VolumeStepsDef = 5;

  // register reset values
  localparam logic [DebounceW-1:0]    DebounceRst    = 8'd30;
  localparam logic [LongPressW-1:0]   LongPressRst   = 12'd800;
  localparam logic [ClickWindowW-1:0] ClickWindowRst = 10'd300;

  // counter limits and volume scale
  localparam logic [ClickCntW-1:0]  ClickMax = 3'd4;
  localparam logic [LongPressW-1:0] HeldMax  = 12'd4095;
  localparam int unsigned VolLow  = 20;
  localparam int unsigned VolSpan = 80;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce    = 2'd0,
    CfgLongPress   = 2'd1,
    CfgClickWindow = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  // gesture codes
  typedef enum logic [GestureW-1:0] {
    GestNone    = 2'd0,
    GestWake    = 2'd1,
    GestVolUp   = 2'd2,
    GestVolDown = 2'd3
  } gesture_e;

  // what one button lane reports for a tick
  typedef struct packed {
    logic click;
    logic long_press;
  } lane_res_t;

endpackage

// ----- hw/rtl/bcg_in_if.sv -----
// ----------------------------------------------------------------------------
// bcg_in_if
// Tick channel: valid/ready handshake with the raw levels of both buttons.
// ----------------------------------------------------------------------------
interface bcg_in_if;
  logic valid;
  logic ready;
  logic boot_level;
  logic ext_level;

  modport source (output valid, output boot_level, output ext_level, input ready);
  modport sink   (input valid, input boot_level, input ext_level, output ready);
endinterface

// ----- hw/rtl/bcg_out_if.sv -----
// ----------------------------------------------------------------------------
// bcg_out_if
// Result channel: valid/ready handshake with long presses, gesture and volume.
// ----------------------------------------------------------------------------
interface bcg_out_if;
  logic                                valid;
  logic                                ready;
  logic [bcg_pkg::LongsW-1:0]          long_presses;
  logic [bcg_pkg::GestureW-1:0]        gesture;
  logic [bcg_pkg::VolPctW-1:0]         volume_percent;

  modport source (output valid, output long_presses, output gesture,
                  output volume_percent, input ready);
  modport sink   (input valid, input long_presses, input gesture,
                  input volume_percent, output ready);
endinterface

// ----- hw/rtl/button_click_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// button_click_gesture_classifier
// Debounces push buttons per tick, detects long presses and classifies click
// bursts into wake / volume up / volume down with a clamped volume level.
//
//   channel   dir  handshake         payload
//   in_chan   in   valid/ready       boot_level, ext_level (active low)
//   out_chan  out  valid/ready       long_presses, gesture, volume_percent
//   cfg       in   cfg_we_i          cfg_idx_i, cfg_data_i (no read-back)
//
// One tick per cycle unless the output stalls; its result appears in the
// output register the next cycle, as lane and merge logic are combinational.
// A tick is taken while the output register is empty or being drained. Reset
// inits all state but the output data; the first tick seeds the stable levels.
// ----------------------------------------------------------------------------
module button_click_gesture_classifier #(
  parameter int unsigned NUM_BUTTONS  = bcg_pkg::NumButtonsDef,
  parameter int unsigned VOLUME_STEPS = bcg_pkg::VolumeStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bcg_in_if.sink                            in_chan,
  bcg_out_if.source                         out_chan,
  input  logic                              cfg_we_i,
  input  logic [bcg_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bcg_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [bcg_pkg::DebounceW-1:0]     debounce_q;
  logic [bcg_pkg::LongPressW-1:0]    long_press_q;
  logic [bcg_pkg::ClickWindowW-1:0]  click_window_q;

  logic                              primed_q;
  logic                              accept;
  logic                              out_valid_q;
  logic [bcg_pkg::LongsW-1:0]        longs_q;
  bcg_pkg::gesture_e                 gesture_q;
  logic [bcg_pkg::VolPctW-1:0]       vol_pct_q;

  logic [NUM_BUTTONS-1:0]            pressed;
  bcg_pkg::lane_res_t                lane_res [NUM_BUTTONS];
  logic [bcg_pkg::LongsW-1:0]        longs;
  bcg_pkg::gesture_e                 gesture;
  logic [bcg_pkg::VolPctW-1:0]       vol_pct;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= bcg_pkg::DebounceRst;
      long_press_q   <= bcg_pkg::LongPressRst;
      click_window_q <= bcg_pkg::ClickWindowRst;
    end else if (cfg_we_i) begin
      unique case (bcg_pkg::cfg_idx_e'(cfg_idx_i))
        bcg_pkg::CfgDebounce:    debounce_q     <= cfg_data_i[bcg_pkg::DebounceW-1:0];
        bcg_pkg::CfgLongPress:   long_press_q   <= cfg_data_i[bcg_pkg::LongPressW-1:0];
        bcg_pkg::CfgClickWindow: click_window_q <= cfg_data_i[bcg_pkg::ClickWindowW-1:0];
        default: ;
      endcase
    end
  end

  // input transfer whenever the output register is free or draining
  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // first-tick marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (accept) begin
      primed_q <= 1'b1;
    end
  end

  // button lanes; buttons beyond the two inputs read as released
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    if (b == 0) begin : g_boot
      assign pressed[b] = !in_chan.boot_level;
    end else if (b == 1) begin : g_ext
      assign pressed[b] = !in_chan.ext_level;
    end else begin : g_none
      assign pressed[b] = 1'b0;
    end

    bcg_lane u_lane (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .accept_i           (accept),
      .primed_i           (primed_q),
      .pressed_i          (pressed[b]),
      .debounce_ticks_i   (debounce_q),
      .long_press_ticks_i (long_press_q),
      .res_o              (lane_res[b])
    );
  end

  // merge of lane results
  bcg_merge #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .VOLUME_STEPS (VOLUME_STEPS)
  ) u_merge (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .accept_i             (accept),
    .lane_res_i           (lane_res),
    .click_window_ticks_i (click_window_q),
    .long_presses_o       (longs),
    .gesture_o            (gesture),
    .volume_percent_o     (vol_pct)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      longs_q   <= longs;
      gesture_q <= gesture;
      vol_pct_q <= vol_pct;
    end
  end

  assign out_chan.valid          = out_valid_q;
  assign out_chan.long_presses   = longs_q;
  assign out_chan.gesture        = gesture_q;
  assign out_chan.volume_percent = vol_pct_q;

endmodule

// ----- hw/rtl/bcg_lane.sv -----
// ----------------------------------------------------------------------------
// bcg_lane
// Per-button core: debounce, arm on press, held time and long-press detect.
// ----------------------------------------------------------------------------
module bcg_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                primed_i,
  input  logic                                pressed_i,
  input  logic [bcg_pkg::DebounceW-1:0]       debounce_ticks_i,
  input  logic [bcg_pkg::LongPressW-1:0]      long_press_ticks_i,
  output bcg_pkg::lane_res_t                  res_o
);

  localparam int unsigned ElapsedW = bcg_pkg::LongPressW + 1;

  logic                               stable_q, stable_d;
  logic                               armed_q, armed_d;
  logic [bcg_pkg::LongPressW-1:0]     held_q, held_d;
  logic [bcg_pkg::DebounceW-1:0]      tmr_q, tmr_d;

  logic                               stable;
  logic                               confirm;
  logic [ElapsedW-1:0]                elapsed;
  logic [ElapsedW-1:0]                elapsed_eff;

  // next state of one button for this tick
  always_comb begin
    stable      = primed_i ? stable_q : pressed_i;
    elapsed     = armed_q ? ({1'b0, held_q} + ElapsedW'(1)) : '0;
    held_d      = held_q;
    if (armed_q) begin
      held_d = (elapsed > {1'b0, bcg_pkg::HeldMax}) ? bcg_pkg::HeldMax
                                                     : elapsed[bcg_pkg::LongPressW-1:0];
    end
    armed_d     = armed_q;
    stable_d    = stable;
    tmr_d       = tmr_q;
    confirm     = 1'b0;
    res_o.click = 1'b0;

    // debounce: re-sample the level when the timer runs out
    if (tmr_q != '0) begin
      tmr_d   = tmr_q - bcg_pkg::DebounceW'(1);
      confirm = (tmr_q == bcg_pkg::DebounceW'(1)) && (pressed_i != stable);
    end else if (pressed_i != stable) begin
      if (debounce_ticks_i == '0) begin
        confirm = 1'b1;
      end else begin
        tmr_d = debounce_ticks_i;
      end
    end

    // confirmed edge: press arms, release of an armed button clicks
    elapsed_eff = elapsed;
    if (confirm) begin
      stable_d = pressed_i;
      if (pressed_i) begin
        held_d      = '0;
        elapsed_eff = '0;
        armed_d     = 1'b1;
      end else if (armed_q) begin
        armed_d     = 1'b0;
        res_o.click = 1'b1;
      end
    end

    // long press
    res_o.long_press = armed_d && pressed_i &&
                       (elapsed_eff > {1'b0, long_press_ticks_i});
    if (res_o.long_press) begin
      armed_d = 1'b0;
    end
  end

  // lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      armed_q  <= 1'b0;
      held_q   <= '0;
      tmr_q    <= '0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      armed_q  <= armed_d;
      held_q   <= held_d;
      tmr_q    <= tmr_d;
    end
  end

endmodule

// ----- hw/rtl/bcg_merge.sv -----
// ----------------------------------------------------------------------------
// bcg_merge
// Combines the lanes: shared click count, click window, gesture and volume.
// ----------------------------------------------------------------------------
module bcg_merge #(
  parameter int unsigned NUM_BUTTONS  = bcg_pkg::NumButtonsDef,
  parameter int unsigned VOLUME_STEPS = bcg_pkg::VolumeStepsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  bcg_pkg::lane_res_t                   lane_res_i [NUM_BUTTONS],
  input  logic [bcg_pkg::ClickWindowW-1:0]     click_window_ticks_i,
  output logic [bcg_pkg::LongsW-1:0]           long_presses_o,
  output bcg_pkg::gesture_e                    gesture_o,
  output logic [bcg_pkg::VolPctW-1:0]          volume_percent_o
);

  localparam int unsigned CntW   = $clog2(NUM_BUTTONS + 1);
  localparam int unsigned SumW   = $clog2(4 + NUM_BUTTONS + 1);
  localparam int unsigned IdxW   = (VOLUME_STEPS > 1) ? $clog2(VOLUME_STEPS) : 1;
  localparam int unsigned VolDiv = (VOLUME_STEPS > 1) ? (VOLUME_STEPS - 1) : 1;

  logic [bcg_pkg::ClickCntW-1:0]      count_q, count_d;
  logic [bcg_pkg::ClickWindowW-1:0]   win_q, win_d;
  logic [IdxW-1:0]                    vol_q, vol_d;

  logic [CntW-1:0]                    n_clicks;
  logic [CntW-1:0]                    n_longs;
  logic                               any_click;
  logic                               any_long;
  logic [SumW-1:0]                    count_sum;
  logic                               fire;
  logic [bcg_pkg::VolPctW-1:0]        vol_tab [VOLUME_STEPS];

  // volume level table
  for (genvar k = 0; k < VOLUME_STEPS; k++) begin : g_vol
    localparam int unsigned Pct = bcg_pkg::VolLow + (k * bcg_pkg::VolSpan) / VolDiv;
    assign vol_tab[k] = bcg_pkg::VolPctW'(Pct);
  end

  // count what the lanes found
  always_comb begin
    n_clicks = '0;
    n_longs  = '0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      n_clicks = n_clicks + CntW'(lane_res_i[k].click);
      n_longs  = n_longs + CntW'(lane_res_i[k].long_press);
    end
    any_click = (n_clicks != '0);
    any_long  = (n_longs != '0);
  end

  // click count, window and dispatch
  always_comb begin
    count_sum = SumW'(count_q) + SumW'(n_clicks);
    count_d   = count_q;
    win_d     = win_q;
    vol_d     = vol_q;
    fire      = 1'b0;
    gesture_o = bcg_pkg::GestNone;

    if (any_long) begin
      count_d = '0;
      win_d   = '0;
    end else if (any_click) begin
      count_d = (count_sum > SumW'(bcg_pkg::ClickMax)) ? bcg_pkg::ClickMax
                                                        : count_sum[bcg_pkg::ClickCntW-1:0];
      win_d   = click_window_ticks_i;
      fire    = (click_window_ticks_i == '0);
    end else if (win_q != '0) begin
      win_d = win_q - bcg_pkg::ClickWindowW'(1);
      fire  = (win_q == bcg_pkg::ClickWindowW'(1));
    end

    if (fire) begin
      if (count_d == bcg_pkg::ClickCntW'(2)) begin
        gesture_o = bcg_pkg::GestVolUp;
        if (vol_q != IdxW'(VOLUME_STEPS - 1)) begin
          vol_d = vol_q + IdxW'(1);
        end
      end else if (count_d == bcg_pkg::ClickCntW'(3)) begin
        gesture_o = bcg_pkg::GestVolDown;
        if (vol_q != '0) begin
          vol_d = vol_q - IdxW'(1);
        end
      end else begin
        gesture_o = bcg_pkg::GestWake;
      end
      count_d = '0;
    end

    long_presses_o   = bcg_pkg::LongsW'(n_longs);
    volume_percent_o = vol_tab[vol_d];
  end

  // shared state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      win_q   <= '0;
      vol_q   <= IdxW'(1);
    end else if (accept_i) begin
      count_q <= count_d;
      win_q   <= win_d;
      vol_q   <= vol_d;
    end
  end

endmodule
